[design/msvep_pkg.sv]
`timescale 1ns / 1ps

package msvep_pkg;

    // Defaults for the top-level parameters.
    localparam int unsigned SINE_TABLE_DEPTH_DEF = 256;
    localparam int unsigned PHASE_BITS_DEF = 32;
    localparam int unsigned SAMPLE_BITS_DEF = 16;

    // Fixed field widths.
    localparam int unsigned STATUS_W = 8;
    localparam int unsigned DATA_W = 7;
    localparam int unsigned NOTE_COUNT = 2 ** DATA_W;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned LEVEL_W = 25;
    localparam int unsigned LEVEL_FRAC = 24;
    localparam int unsigned PAN_W = 7;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [LEVEL_W-1:0] UNITY = LEVEL_W'(1) << LEVEL_FRAC;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK_RATE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_RATE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUSTAIN_LEVEL = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEAK_LEVEL = 2'd3;

    localparam logic [LEVEL_W-1:0] ATTACK_RATE_RST = 25'd38044;
    localparam logic [LEVEL_W-1:0] DECAY_RATE_RST = 25'd543;
    localparam logic [LEVEL_W-1:0] SUSTAIN_LEVEL_RST = 25'd0;
    localparam logic [LEVEL_W-1:0] PEAK_LEVEL_RST = UNITY;

    // MIDI codes.
    localparam logic [STATUS_W-1:0] STATUS_NOTE_ON = 8'h90;
    localparam logic [STATUS_W-1:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [DATA_W-1:0] CC_PAN_STEP = 7'd110;
    localparam logic [DATA_W-1:0] CC_PAN_CENTER = 7'd86;
    localparam logic [DATA_W-1:0] PAN_STEP_MID = 7'd16;

    localparam int unsigned PAN_SCALE = 100;
    localparam logic [PAN_W-1:0] PAN_MAX = PAN_W'(PAN_SCALE);
    localparam logic [PAN_W-1:0] PAN_CENTER = 7'd50;

    // Pitch table: A4 increment with 8 fraction bits and semitone ratios in Q24.
    localparam logic [63:0] INC_A4_Q8 = 64'd10970184041;
    localparam int unsigned SEMITONES = 12;
    localparam int unsigned NOTE_OFFSET = 3;
    localparam int unsigned INC_SHIFT_BASE = 70;
    localparam logic [LEVEL_W-1:0] SEMITONE_Q24 [SEMITONES] = '{
        25'd16777216, 25'd17774841, 25'd18831788, 25'd19951585,
        25'd21137968, 25'd22394897, 25'd23726566, 25'd25137421,
        25'd26632170, 25'd28215802, 25'd29893600, 25'd31671166
    };

    // Odd Taylor coefficients of sin(pi/2 * x) in Q30.
    localparam int unsigned Q_FRAC = 30;
    localparam logic [63:0] SIN_A1 = 64'd1686629713;
    localparam logic [63:0] SIN_A3 = 64'd693598668;
    localparam logic [63:0] SIN_A5 = 64'd85569306;
    localparam logic [63:0] SIN_A7 = 64'd5026995;
    localparam logic [63:0] SIN_A9 = 64'd172272;

    function automatic logic [LEVEL_W-1:0] clamp_unity(input logic [LEVEL_W-1:0] v);
        return (v > UNITY) ? UNITY : v;
    endfunction

    // Phase increment of one note; only ever evaluated with constant arguments.
    function automatic logic [63:0] note_increment(input int unsigned note,
                                                   input int unsigned phase_bits);
        int unsigned m;
        int unsigned oct;
        int unsigned k;
        int unsigned sh;
        logic [63:0] prod;
        m = note + NOTE_OFFSET;
        oct = m / SEMITONES;
        k = m % SEMITONES;
        sh = INC_SHIFT_BASE - phase_bits - oct;
        prod = INC_A4_Q8 * 64'(SEMITONE_Q24[k]);
        return (prod + (64'd1 << (sh - 1))) >> sh;
    endfunction

    // One entry of the quarter-wave table; only ever evaluated with constant arguments.
    function automatic logic [63:0] quarter_value(input int unsigned j,
                                                  input int unsigned qtr_w,
                                                  input int unsigned sample_bits);
        logic [63:0] fs;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] y;
        logic [63:0] v;
        fs = (64'd1 << (sample_bits - 1)) - 64'd1;
        x = 64'(j) << (Q_FRAC - qtr_w);
        x2 = (x * x) >> Q_FRAC;
        t = SIN_A7 - ((x2 * SIN_A9) >> Q_FRAC);
        t = SIN_A5 - ((x2 * t) >> Q_FRAC);
        t = SIN_A3 - ((x2 * t) >> Q_FRAC);
        t = SIN_A1 - ((x2 * t) >> Q_FRAC);
        y = (x * t) >> Q_FRAC;
        v = (y * fs + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC;
        return (v > fs) ? fs : v;
    endfunction

endpackage

[design/msvep_note_if.sv]
`timescale 1ns / 1ps

interface msvep_note_if;
    logic                              valid;
    logic                              ready;
    logic                              msg_valid;
    logic [msvep_pkg::STATUS_W-1:0]    status_byte;
    logic [msvep_pkg::DATA_W-1:0]      data_one;
    logic [msvep_pkg::DATA_W-1:0]      data_two;

    modport source (output valid, msg_valid, status_byte, data_one, data_two, input ready);
    modport sink (input valid, msg_valid, status_byte, data_one, data_two, output ready);
endinterface

[design/msvep_sample_if.sv]
`timescale 1ns / 1ps

interface msvep_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [msvep_pkg::SAMPLE_W-1:0] left_sample;
    logic signed [msvep_pkg::SAMPLE_W-1:0] right_sample;

    modport source (output valid, left_sample, right_sample, input ready);
    modport sink (input valid, left_sample, right_sample, output ready);
endinterface

[design/msvep_cfg_if.sv]
`timescale 1ns / 1ps

interface msvep_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [msvep_pkg::CFG_INDEX_W-1:0]   index;
    logic [msvep_pkg::LEVEL_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/midi_sine_voice_envelope_pan_core.sv]
`timescale 1ns / 1ps

// Channel     Direction  Moves
// note_in     in         one sample tick with an optional MIDI message
// sample_out  out        left and right signed samples for that tick
// cfg         in         register write: index and 25-bit data, always ready
//
// Each item runs through ST_LOOK, ST_PREP, the envelope multiply in ST_MUL, one
// 4-bit digit per cycle, ST_RND, the divide by 100 of the pan split in ST_DIV,
// two quotient bits per cycle, and ST_DONE; a new item is taken only in ST_IDLE.
// Reset clears phase and level, centers pan and loads the register defaults.
// A stalled output holds its item; the next result waits in ST_DONE meanwhile.

module midi_sine_voice_envelope_pan_core #(
    parameter int unsigned SINE_TABLE_DEPTH = msvep_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int unsigned PHASE_BITS = msvep_pkg::PHASE_BITS_DEF,
    parameter int unsigned SAMPLE_BITS = msvep_pkg::SAMPLE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    msvep_note_if.sink            note_in,
    msvep_sample_if.source        sample_out,
    msvep_cfg_if.sink             cfg
);

    localparam int unsigned LEVEL_W = msvep_pkg::LEVEL_W;
    localparam int unsigned PAN_W = msvep_pkg::PAN_W;
    localparam int unsigned SAMPLE_W = msvep_pkg::SAMPLE_W;
    localparam int unsigned ADDR_W = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned QTR_W = ADDR_W - 2;
    localparam int unsigned QTR = SINE_TABLE_DEPTH / 4;
    localparam int unsigned MAG_W = SAMPLE_BITS - 1;
    localparam int unsigned K_W = MAG_W + PAN_W;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned LVL_DIGITS = (LEVEL_W + DIGIT_W - 1) / DIGIT_W;
    localparam int unsigned LVL_SR_W = LVL_DIGITS * DIGIT_W;
    localparam int unsigned P_W = K_W + LEVEL_W;
    localparam int unsigned DIV_STEPS = (K_W + 1) / 2;
    localparam int unsigned DIV_SR_W = 2 * DIV_STEPS;
    localparam int unsigned REM_W = 7;
    localparam int unsigned TRIAL_W = REM_W + 2;
    localparam int unsigned MAX_STEPS = (LVL_DIGITS > DIV_STEPS) ? LVL_DIGITS : DIV_STEPS;
    localparam int unsigned CNT_W = $clog2(MAX_STEPS);
    localparam int unsigned LANES = 2;

    localparam logic [QTR_W:0] QTR_VAL = (QTR_W + 1)'(QTR);
    localparam logic [CNT_W-1:0] LVL_CNT_INIT = CNT_W'(LVL_DIGITS - 1);
    localparam logic [CNT_W-1:0] DIV_CNT_INIT = CNT_W'(DIV_STEPS - 1);
    localparam logic [P_W-1:0] ROUND_HALF =
        P_W'(msvep_pkg::PAN_SCALE / 2) << msvep_pkg::LEVEL_FRAC;
    localparam logic [TRIAL_W-1:0] DIV_ONE = TRIAL_W'(msvep_pkg::PAN_SCALE);
    localparam logic [TRIAL_W-1:0] DIV_TWO = TRIAL_W'(2 * msvep_pkg::PAN_SCALE);
    localparam logic [TRIAL_W-1:0] DIV_THREE = TRIAL_W'(3 * msvep_pkg::PAN_SCALE);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_LOOK = 7'b0000010,
        ST_PREP = 7'b0000100,
        ST_MUL  = 7'b0001000,
        ST_RND  = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    typedef enum logic [2:0] {
        ENV_ATTACK  = 3'b001,
        ENV_DECAY   = 3'b010,
        ENV_SUSTAIN = 3'b100
    } env_stage_t;

    state_t                    state_reg;
    env_stage_t                env_stage_reg;
    env_stage_t                env_stage_next;
    logic [LEVEL_W-1:0]        env_level_reg;
    logic [LEVEL_W-1:0]        env_level_next;
    logic [PHASE_BITS-1:0]     phase_acc_reg;
    logic [PHASE_BITS-1:0]     phase_inc_reg;
    logic [PAN_W-1:0]          pan_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      out_valid_reg;

    logic [LEVEL_W-1:0]        attack_rate_reg;
    logic [LEVEL_W-1:0]        decay_rate_reg;
    logic [LEVEL_W-1:0]        sustain_level_reg;
    logic [LEVEL_W-1:0]        peak_level_reg;

    logic [MAG_W-1:0]          mag_reg;
    logic                      neg_reg;
    logic [LVL_SR_W-1:0]       lvl_sr_reg;
    logic [PAN_W-1:0]          wt_reg [LANES];
    logic [K_W-1:0]            k_reg [LANES];
    logic [P_W-1:0]            acc_reg [LANES];
    logic [DIV_SR_W-1:0]       div_sr_reg [LANES];
    logic [REM_W-1:0]          rem_reg [LANES];
    logic [SAMPLE_W-1:0]       quo_reg [LANES];
    logic [SAMPLE_W-1:0]       left_reg;
    logic [SAMPLE_W-1:0]       right_reg;

    logic [MAG_W-1:0]          sine_lut [QTR + 1];
    logic [PHASE_BITS-1:0]     inc_lut [msvep_pkg::NOTE_COUNT];

    logic                      in_accept;
    logic                      out_load;
    logic [ADDR_W-1:0]         phase_idx;
    logic [QTR_W:0]            lut_addr;
    logic [LEVEL_W-1:0]        sus_c;
    logic [LEVEL_W-1:0]        atk_c;
    logic [LEVEL_W-1:0]        dec_c;
    logic [LEVEL_W-1:0]        peak_c;
    logic [LEVEL_W:0]          level_sum;
    logic [DIGIT_W-1:0]        lvl_digit;
    logic [K_W+DIGIT_W-1:0]    part [LANES];
    logic [P_W-1:0]            acc_next [LANES];
    logic [P_W-1:0]            rounded [LANES];
    logic [TRIAL_W-1:0]        trial [LANES];
    logic [1:0]                qdig [LANES];
    logic [REM_W-1:0]          rem_next [LANES];
    logic [SAMPLE_W-1:0]       result [LANES];

    // Constant tables, folded at elaboration.
    for (genvar g = 0; g <= QTR; g++) begin : g_sine
        assign sine_lut[g] = MAG_W'(msvep_pkg::quarter_value(g, QTR_W, SAMPLE_BITS));
    end

    for (genvar g = 0; g < msvep_pkg::NOTE_COUNT; g++) begin : g_inc
        assign inc_lut[g] = PHASE_BITS'(msvep_pkg::note_increment(g, PHASE_BITS));
    end

    assign in_accept = note_in.valid && note_in.ready;
    assign note_in.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || sample_out.ready);

    assign sample_out.valid = out_valid_reg;
    assign sample_out.left_sample = left_reg;
    assign sample_out.right_sample = right_reg;

    // Odd quadrants read the quarter wave backwards, from Q down to 1.
    assign phase_idx = phase_acc_reg[PHASE_BITS-1 -: ADDR_W];
    assign lut_addr = phase_idx[QTR_W] ? (QTR_VAL - {1'b0, phase_idx[QTR_W-1:0]})
                                       : {1'b0, phase_idx[QTR_W-1:0]};

    assign sus_c = msvep_pkg::clamp_unity(sustain_level_reg);
    assign atk_c = msvep_pkg::clamp_unity(attack_rate_reg);
    assign dec_c = msvep_pkg::clamp_unity(decay_rate_reg);
    assign peak_c = msvep_pkg::clamp_unity(peak_level_reg);
    assign level_sum = {1'b0, env_level_reg} + {1'b0, atk_c};

    always_comb
    begin
        env_level_next = env_level_reg;
        env_stage_next = env_stage_reg;
        unique case (env_stage_reg)
            ENV_ATTACK:
            begin
                if (env_level_reg >= msvep_pkg::UNITY)
                begin
                    env_stage_next = ENV_DECAY;
                    env_level_next = peak_c;
                end
                else if (level_sum > {1'b0, msvep_pkg::UNITY})
                begin
                    env_level_next = msvep_pkg::UNITY;
                end
                else
                begin
                    env_level_next = level_sum[LEVEL_W-1:0];
                end
            end
            ENV_DECAY:
            begin
                // Decay walks toward sustain from either side.
                if (env_level_reg > sus_c)
                begin
                    env_level_next = ((env_level_reg - sus_c) > dec_c) ?
                                     (env_level_reg - dec_c) : sus_c;
                end
                else if (env_level_reg < sus_c)
                begin
                    env_level_next = ((sus_c - env_level_reg) > dec_c) ?
                                     (env_level_reg + dec_c) : sus_c;
                end
                if (env_level_next == sus_c)
                begin
                    env_stage_next = ENV_SUSTAIN;
                end
            end
            default:
            begin
                env_level_next = sus_c;
            end
        endcase
    end

    assign lvl_digit = lvl_sr_reg[LVL_SR_W-1 -: DIGIT_W];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            part[i] = (K_W + DIGIT_W)'(k_reg[i]) * (K_W + DIGIT_W)'(lvl_digit);
            acc_next[i] = {acc_reg[i][P_W-DIGIT_W-1:0], DIGIT_W'(0)} + P_W'(part[i]);
            rounded[i] = acc_reg[i] + ROUND_HALF;
            trial[i] = {rem_reg[i], div_sr_reg[i][DIV_SR_W-1 -: 2]};
            if (trial[i] >= DIV_THREE)
            begin
                qdig[i] = 2'd3;
                rem_next[i] = REM_W'(trial[i] - DIV_THREE);
            end
            else if (trial[i] >= DIV_TWO)
            begin
                qdig[i] = 2'd2;
                rem_next[i] = REM_W'(trial[i] - DIV_TWO);
            end
            else if (trial[i] >= DIV_ONE)
            begin
                qdig[i] = 2'd1;
                rem_next[i] = REM_W'(trial[i] - DIV_ONE);
            end
            else
            begin
                qdig[i] = 2'd0;
                rem_next[i] = REM_W'(trial[i]);
            end
            result[i] = neg_reg ? (SAMPLE_W'(0) - quo_reg[i]) : quo_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_rate_reg <= msvep_pkg::ATTACK_RATE_RST;
            decay_rate_reg <= msvep_pkg::DECAY_RATE_RST;
            sustain_level_reg <= msvep_pkg::SUSTAIN_LEVEL_RST;
            peak_level_reg <= msvep_pkg::PEAK_LEVEL_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                msvep_pkg::CFG_ATTACK_RATE:   attack_rate_reg <= cfg.data;
                msvep_pkg::CFG_DECAY_RATE:    decay_rate_reg <= cfg.data;
                msvep_pkg::CFG_SUSTAIN_LEVEL: sustain_level_reg <= cfg.data;
                msvep_pkg::CFG_PEAK_LEVEL:    peak_level_reg <= cfg.data;
                default:                      peak_level_reg <= peak_level_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_acc_reg <= '0;
            phase_inc_reg <= '0;
            env_level_reg <= '0;
            env_stage_reg <= ENV_ATTACK;
            pan_reg <= msvep_pkg::PAN_CENTER;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (sample_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= ST_LOOK;
                        if (note_in.msg_valid)
                        begin
                            if (note_in.status_byte == msvep_pkg::STATUS_NOTE_ON)
                            begin
                                phase_acc_reg <= '0;
                                phase_inc_reg <= inc_lut[note_in.data_one];
                                env_level_reg <= '0;
                                env_stage_reg <= ENV_ATTACK;
                            end
                            else if (note_in.status_byte == msvep_pkg::STATUS_NOTE_OFF)
                            begin
                                pan_reg <= pan_reg;
                            end
                            else if (note_in.data_one == msvep_pkg::CC_PAN_STEP)
                            begin
                                if (note_in.data_two < msvep_pkg::PAN_STEP_MID)
                                begin
                                    if (pan_reg != '0)
                                    begin
                                        pan_reg <= pan_reg - 7'd1;
                                    end
                                end
                                else if (note_in.data_two > msvep_pkg::PAN_STEP_MID)
                                begin
                                    if (pan_reg < msvep_pkg::PAN_MAX)
                                    begin
                                        pan_reg <= pan_reg + 7'd1;
                                    end
                                end
                            end
                            else if (note_in.data_one == msvep_pkg::CC_PAN_CENTER)
                            begin
                                pan_reg <= msvep_pkg::PAN_CENTER;
                            end
                        end
                    end
                end
                ST_LOOK:
                begin
                    // The sample uses the phase and level before this advance.
                    phase_acc_reg <= phase_acc_reg + phase_inc_reg;
                    env_level_reg <= env_level_next;
                    env_stage_reg <= env_stage_next;
                    state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    cnt_reg <= LVL_CNT_INIT;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_RND;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end
                ST_RND:
                begin
                    cnt_reg <= DIV_CNT_INIT;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_LOOK:
            begin
                mag_reg <= sine_lut[lut_addr];
                neg_reg <= phase_idx[ADDR_W-1];
                lvl_sr_reg <= LVL_SR_W'(env_level_reg);
                wt_reg[0] <= msvep_pkg::PAN_MAX - pan_reg;
                wt_reg[1] <= pan_reg;
            end
            ST_PREP:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    k_reg[i] <= K_W'(mag_reg) * K_W'(wt_reg[i]);
                    acc_reg[i] <= '0;
                end
            end
            ST_MUL:
            begin
                // Level digits enter most significant first.
                lvl_sr_reg <= {lvl_sr_reg[LVL_SR_W-DIGIT_W-1:0], DIGIT_W'(0)};
                for (int i = 0; i < LANES; i++)
                begin
                    acc_reg[i] <= acc_next[i];
                end
            end
            ST_RND:
            begin
                // Rounding to the nearest 1/100 of the 2^24 scale, then divide by 100.
                for (int i = 0; i < LANES; i++)
                begin
                    div_sr_reg[i] <= DIV_SR_W'(rounded[i][msvep_pkg::LEVEL_FRAC +: K_W]);
                    rem_reg[i] <= '0;
                    quo_reg[i] <= '0;
                end
            end
            ST_DIV:
            begin
                // Only the low 16 quotient bits survive; the rest fall off the top.
                for (int i = 0; i < LANES; i++)
                begin
                    div_sr_reg[i] <= {div_sr_reg[i][DIV_SR_W-3:0], 2'b00};
                    rem_reg[i] <= rem_next[i];
                    quo_reg[i] <= {quo_reg[i][SAMPLE_W-3:0], qdig[i]};
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    left_reg <= result[0];
                    right_reg <= result[1];
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !note_in.ready)
        else $error("item accepted while the previous one is still in work");

    a_pan_single_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pan_reg != $past(pan_reg)) |->
            (pan_reg == $past(pan_reg) + 7'd1 || pan_reg + 7'd1 == $past(pan_reg) ||
             pan_reg == msvep_pkg::PAN_CENTER))
        else $error("pan moved by more than one step");

    a_phase_update: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_acc_reg != $past(phase_acc_reg)) |->
            ($past(state_reg) == ST_LOOK || $past(in_accept)))
        else $error("phase changed outside note-on or advance");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("output item raised before the division finished");
`endif

endmodule

[tb/voice_sample_checker.sv]
`timescale 1ns / 1ps

module voice_sample_checker (
    input  logic    clk,
    input  logic    rst_n,
    msvep_note_if   note_in,
    msvep_sample_if sample_out,
    msvep_cfg_if    cfg,
    output int      mismatches,
    output int      pending,
    output int      samples_checked
);
    import msvep_pkg::*;

    localparam int unsigned DEPTH = SINE_TABLE_DEPTH_DEF;
    localparam int unsigned PBITS = PHASE_BITS_DEF;
    localparam int unsigned SBITS = SAMPLE_BITS_DEF;
    localparam int unsigned QTR = DEPTH / 4;
    localparam int PRINT_CAP = 100;

    typedef enum logic [1:0] {
        ENV_ATTACK  = 2'd0,
        ENV_DECAY   = 2'd1,
        ENV_SUSTAIN = 2'd2
    } env_stage_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } stereo_t;

    stereo_t expected_samples[$];

    logic [LEVEL_W-1:0] attack_rate;
    logic [LEVEL_W-1:0] decay_rate;
    logic [LEVEL_W-1:0] sustain_level;
    logic [LEVEL_W-1:0] peak_level;
    logic [PBITS-1:0]   phase;
    logic [PBITS-1:0]   phase_step;
    logic [LEVEL_W-1:0] level;
    env_stage_t         stage;
    logic [PAN_W-1:0]   pan;

    function automatic logic [LEVEL_W-1:0] level_cap(input logic [31:0] v);
        return (v > 32'(UNITY)) ? UNITY : v[LEVEL_W-1:0];
    endfunction

    // Quarter-wave magnitude at table offset j (0..QTR), full scale 2^(SBITS-1)-1.
    function automatic logic [SAMPLE_W-1:0] quarter_level(input int unsigned j);
        logic [63:0] full;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] poly;
        logic [63:0] y;
        logic [63:0] v;
        full = (64'd1 << (SBITS - 1)) - 64'd1;
        x = (64'(j) << Q_FRAC) / 64'(QTR);
        x2 = (x * x) >> Q_FRAC;
        poly = SIN_A7 - ((x2 * SIN_A9) >> Q_FRAC);
        poly = SIN_A5 - ((x2 * poly) >> Q_FRAC);
        poly = SIN_A3 - ((x2 * poly) >> Q_FRAC);
        poly = SIN_A1 - ((x2 * poly) >> Q_FRAC);
        y = (x * poly) >> Q_FRAC;
        v = (y * full + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC;
        if (v > full)
            v = full;
        return SAMPLE_W'(v);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pan_weighted(input logic [SAMPLE_W-1:0] mag,
                                                         input logic neg,
                                                         input logic [LEVEL_W-1:0] lvl,
                                                         input int unsigned weight);
        logic [63:0] den;
        logic [63:0] r;
        den = 64'(PAN_SCALE) << LEVEL_FRAC;
        r = (64'(mag) * 64'(lvl) * 64'(weight) + den / 2) / den;
        if (neg)
            r = 64'd0 - r;
        return r[SAMPLE_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        // Past the cap the count still grows, so the verdict is unaffected.
        if (mismatches <= PRINT_CAP)
            $display("%0t ERROR: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        stereo_t          want;
        stereo_t          got;
        logic [63:0]      idx;
        logic [63:0]      scaled;
        int unsigned      quad;
        int unsigned      j;
        int unsigned      semis;
        int unsigned      octave;
        int unsigned      shift;
        logic [SAMPLE_W-1:0] mag;
        logic [LEVEL_W-1:0]  sus;
        logic [LEVEL_W-1:0]  rate;
        if (!rst_n)
        begin
            attack_rate = ATTACK_RATE_RST;
            decay_rate = DECAY_RATE_RST;
            sustain_level = SUSTAIN_LEVEL_RST;
            peak_level = PEAK_LEVEL_RST;
            phase = '0;
            phase_step = '0;
            level = '0;
            stage = ENV_ATTACK;
            pan = PAN_CENTER;
            expected_samples.delete();
            pending = 0;
            mismatches = 0;
            samples_checked = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_ATTACK_RATE:   attack_rate = cfg.data;
                    CFG_DECAY_RATE:    decay_rate = cfg.data;
                    CFG_SUSTAIN_LEVEL: sustain_level = cfg.data;
                    CFG_PEAK_LEVEL:    peak_level = cfg.data;
                    default:           ;
                endcase
            end

            // Results are checked before this edge's tick is predicted: a result
            // always belongs to an earlier item.
            if (sample_out.valid && sample_out.ready)
            begin
                got.left = sample_out.left_sample;
                got.right = sample_out.right_sample;
                if (expected_samples.size() == 0)
                    report_mismatch($sformatf("sample %0d arrived with no tick pending (%0d, %0d)",
                                              samples_checked, $signed(got.left),
                                              $signed(got.right)));
                else
                begin
                    want = expected_samples.pop_front();
                    if (want.left != got.left)
                        report_mismatch($sformatf("sample %0d left: expected %0d, got %0d",
                                                  samples_checked, $signed(want.left),
                                                  $signed(got.left)));
                    if (want.right != got.right)
                        report_mismatch($sformatf("sample %0d right: expected %0d, got %0d",
                                                  samples_checked, $signed(want.right),
                                                  $signed(got.right)));
                end
                samples_checked++;
            end

            if (note_in.valid && note_in.ready)
            begin
                if (note_in.msg_valid)
                begin
                    if (note_in.status_byte == STATUS_NOTE_ON)
                    begin
                        semis = 32'(note_in.data_one) + NOTE_OFFSET;
                        octave = semis / SEMITONES;
                        shift = INC_SHIFT_BASE - PBITS - octave;
                        scaled = INC_A4_Q8 * 64'(SEMITONE_Q24[semis % SEMITONES]);
                        phase_step = PBITS'((scaled + (64'd1 << (shift - 1))) >> shift);
                        phase = '0;
                        level = '0;
                        stage = ENV_ATTACK;
                    end
                    else if (note_in.status_byte != STATUS_NOTE_OFF)
                    begin
                        if (note_in.data_one == CC_PAN_STEP)
                        begin
                            if (note_in.data_two < PAN_STEP_MID)
                            begin
                                if (pan > 0)
                                    pan = pan - PAN_W'(1);
                            end
                            else if (note_in.data_two > PAN_STEP_MID)
                            begin
                                if (pan < PAN_MAX)
                                    pan = pan + PAN_W'(1);
                            end
                        end
                        else if (note_in.data_one == CC_PAN_CENTER)
                            pan = PAN_CENTER;
                    end
                end

                // The sample is taken at the current phase and level, then both move on.
                idx = (64'(phase) * 64'(DEPTH)) >> PBITS;
                quad = 32'((idx / QTR) % 4);
                j = 32'(idx % QTR);
                mag = quad[0] ? quarter_level(QTR - j) : quarter_level(j);
                want.left = pan_weighted(mag, quad[1], level, PAN_SCALE - 32'(pan));
                want.right = pan_weighted(mag, quad[1], level, 32'(pan));
                expected_samples.push_back(want);

                phase = phase + phase_step;
                sus = level_cap(32'(sustain_level));
                case (stage)
                    ENV_ATTACK:
                    begin
                        if (level >= UNITY)
                        begin
                            stage = ENV_DECAY;
                            level = level_cap(32'(peak_level));
                        end
                        else
                            level = level_cap(32'(level) + 32'(level_cap(32'(attack_rate))));
                    end
                    ENV_DECAY:
                    begin
                        rate = level_cap(32'(decay_rate));
                        // A peak below sustain makes the decay climb toward it.
                        if (level > sus)
                            level = (level - sus > rate) ? level - rate : sus;
                        else if (level < sus)
                            level = (sus - level > rate) ? level + rate : sus;
                        if (level == sus)
                            stage = ENV_SUSTAIN;
                    end
                    default:
                        level = sus;
                endcase
            end

            pending = expected_samples.size();
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import msvep_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_TICKS = 1900;
    localparam int SETTLE_CYCLES = 30;
    localparam logic [LEVEL_W-1:0] LEVEL_ALL_ONES = '1;
    localparam logic [STATUS_W-1:0] STATUS_CONTROL = 8'hB0;

    logic clk;
    logic rst_n;

    msvep_note_if   note_in();
    msvep_sample_if sample_out();
    msvep_cfg_if    cfg();

    int mismatches;
    int pending;
    int samples_checked;
    int ticks_sent;
    int notes_sent;
    int pan_msgs_sent;
    int settings_applied;
    int burst_left;
    int hold_requests;
    int holds_done;

    midi_sine_voice_envelope_pan_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .note_in    (note_in),
        .sample_out (sample_out),
        .cfg        (cfg)
    );

    voice_sample_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .note_in         (note_in),
        .sample_out      (sample_out),
        .cfg             (cfg),
        .mismatches      (mismatches),
        .pending         (pending),
        .samples_checked (samples_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one tick and waits until it is taken; gaps between bursts are
    // inserted here so every caller shares the same pacing.
    task automatic send_tick(input logic mv, input logic [STATUS_W-1:0] st,
                             input logic [DATA_W-1:0] d1, input logic [DATA_W-1:0] d2);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
            repeat (gap)
            begin
                @(negedge clk);
                note_in.valid <= 1'b0;
                note_in.msg_valid <= 1'($urandom);
                note_in.status_byte <= STATUS_W'($urandom);
                note_in.data_one <= DATA_W'($urandom);
                note_in.data_two <= DATA_W'($urandom);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        @(negedge clk);
        note_in.valid <= 1'b1;
        note_in.msg_valid <= mv;
        note_in.status_byte <= st;
        note_in.data_one <= d1;
        note_in.data_two <= d2;
        do
            @(posedge clk);
        while (note_in.ready !== 1'b1);
        ticks_sent++;
        if (mv && st == STATUS_NOTE_ON)
            notes_sent++;
        else if (mv && st != STATUS_NOTE_OFF && (d1 == CC_PAN_STEP || d1 == CC_PAN_CENTER))
            pan_msgs_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [LEVEL_W-1:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data <= value;
        do
            @(posedge clk);
        while (cfg.ready !== 1'b1);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Stops offering ticks and waits until every sample is back and the
    // block has had time to go quiet.
    task automatic drain();
        @(negedge clk);
        note_in.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_setting(input logic [LEVEL_W-1:0] atk, input logic [LEVEL_W-1:0] dec,
                                 input logic [LEVEL_W-1:0] sus, input logic [LEVEL_W-1:0] pk);
        drain();
        write_reg(CFG_ATTACK_RATE, atk);
        write_reg(CFG_DECAY_RATE, dec);
        write_reg(CFG_SUSTAIN_LEVEL, sus);
        write_reg(CFG_PEAK_LEVEL, pk);
        settings_applied++;
    endtask

    // Any status except the two note codes, so the item reads as a controller.
    function automatic logic [STATUS_W-1:0] cc_status();
        logic [STATUS_W-1:0] st;
        st = STATUS_W'($urandom);
        if (st == STATUS_NOTE_ON || st == STATUS_NOTE_OFF)
            st = STATUS_CONTROL;
        return st;
    endfunction

    // Output side: stretches of different stall patterns, plus a long
    // hold-off whenever the stimulus asks for one.
    initial
    begin
        int mode;
        int len;
        sample_out.ready = 1'b0;
        forever
        begin
            if (holds_done != hold_requests)
            begin
                holds_done++;
                @(negedge clk);
                sample_out.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                len = $urandom_range(10, 150);
                repeat (len)
                begin
                    @(negedge clk);
                    case (mode)
                        0: sample_out.ready <= 1'b1;
                        1: sample_out.ready <= 1'($urandom);
                        2: sample_out.ready <= ($urandom_range(0, 3) == 0);
                        default: sample_out.ready <= ($urandom_range(0, 9) != 0);
                    endcase
                end
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((note_in.valid && note_in.ready) || (sample_out.valid && sample_out.ready) ||
                (cfg.valid && cfg.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: %0d cycles without any handshake, %0d samples outstanding.",
                 IDLE_LIMIT, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int phase_idx;
        int start;
        int budget;
        int kind;
        int len;
        logic up;
        rst_n = 1'b0;
        note_in.valid = 1'b0;
        note_in.msg_valid = 1'b0;
        note_in.status_byte = '0;
        note_in.data_one = '0;
        note_in.data_two = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_ATTACK_RATE;
        cfg.data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset registers.
        send_tick(1'b0, 8'h00, 7'd0, 7'd0);
        send_tick(1'b0, 8'hFF, 7'd127, 7'd127);
        send_tick(1'b1, STATUS_CONTROL, CC_PAN_STEP, 7'd0);
        send_tick(1'b1, STATUS_NOTE_ON, 7'd127, 7'd0);
        send_tick(1'b0, 8'h00, 7'd0, 7'd0);
        send_tick(1'b0, 8'h55, 7'd42, 7'd21);
        send_tick(1'b1, STATUS_CONTROL, CC_PAN_STEP, 7'd15);
        send_tick(1'b1, 8'h00, CC_PAN_STEP, PAN_STEP_MID);
        send_tick(1'b1, 8'hFF, CC_PAN_STEP, 7'd17);
        send_tick(1'b1, STATUS_CONTROL, CC_PAN_STEP, 7'd127);
        send_tick(1'b1, STATUS_NOTE_OFF, CC_PAN_STEP, 7'd0);
        send_tick(1'b0, STATUS_NOTE_ON, 7'd60, 7'd100);
        send_tick(1'b1, STATUS_CONTROL, CC_PAN_CENTER, 7'd0);
        send_tick(1'b1, 8'h91, 7'd5, 7'd64);
        send_tick(1'b1, STATUS_NOTE_ON, 7'd0, 7'd127);
        send_tick(1'b0, 8'h00, 7'd0, 7'd0);
        send_tick(1'b0, 8'h00, 7'd0, 7'd0);
        send_tick(1'b1, STATUS_NOTE_ON, 7'd69, 7'd64);
        send_tick(1'b0, 8'hAA, 7'd85, 7'd106);
        send_tick(1'b0, 8'h00, 7'd0, 7'd0);
        send_tick(1'b0, 8'h00, 7'd0, 7'd0);

        // Random part: one register setting per phase, the extremes first.
        phase_idx = 0;
        start = ticks_sent;
        while (ticks_sent - start < RANDOM_TICKS)
        begin
            case (phase_idx)
                0: apply_setting(LEVEL_ALL_ONES, LEVEL_ALL_ONES, LEVEL_ALL_ONES, LEVEL_ALL_ONES);
                1: apply_setting(25'd1, 25'd1, 25'd0, 25'd0);
                2: apply_setting(UNITY, UNITY, 25'd0, UNITY);
                3: apply_setting(25'd0, 25'd0, UNITY >> 1, UNITY >> 1);
                4: apply_setting(UNITY >> 1, 25'd0, UNITY >> 2, UNITY);
                5: apply_setting(UNITY >> 2, UNITY >> 6, UNITY - 25'd3, UNITY >> 4);
                6: apply_setting(UNITY >> 4, UNITY >> 7, UNITY >> 2, UNITY);
                7: apply_setting(ATTACK_RATE_RST, DECAY_RATE_RST, SUSTAIN_LEVEL_RST,
                                 PEAK_LEVEL_RST);
                default:
                    apply_setting(
                        ($urandom_range(0, 3) == 0) ? LEVEL_W'($urandom)
                                                    : LEVEL_W'($urandom_range(1, 1 << 22)),
                        ($urandom_range(0, 3) == 0) ? LEVEL_W'($urandom)
                                                    : LEVEL_W'($urandom_range(1, 1 << 20)),
                        ($urandom_range(0, 4) == 0) ? LEVEL_W'($urandom)
                                                    : LEVEL_W'($urandom_range(0, 1 << 24)),
                        ($urandom_range(0, 4) == 0) ? LEVEL_W'($urandom)
                                                    : LEVEL_W'($urandom_range(0, 1 << 24)));
            endcase
            // The output side stalls for a long time while ticks keep coming.
            if (phase_idx == 2 || phase_idx == 9)
                hold_requests++;

            budget = ticks_sent + $urandom_range(100, 200);
            while (ticks_sent < budget)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 45)
                begin
                    // A note followed by a run of plain ticks through its envelope.
                    send_tick(1'b1, STATUS_NOTE_ON, DATA_W'($urandom), DATA_W'($urandom));
                    len = $urandom_range(5, 80);
                    repeat (len)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            send_tick(1'b1, cc_status(), CC_PAN_STEP, DATA_W'($urandom));
                        else
                            send_tick(1'b0, STATUS_W'($urandom), DATA_W'($urandom),
                                      DATA_W'($urandom));
                    end
                end
                else if (kind < 60)
                begin
                    // Pan sweep, long enough at times to hit either clamp.
                    up = 1'($urandom);
                    len = $urandom_range(1, 110);
                    repeat (len)
                        send_tick(1'b1, cc_status(), CC_PAN_STEP,
                                  up ? DATA_W'($urandom_range(17, 127))
                                     : DATA_W'($urandom_range(0, 15)));
                end
                else if (kind < 65)
                    send_tick(1'b1, cc_status(), CC_PAN_CENTER, DATA_W'($urandom));
                else if (kind < 68)
                    send_tick(1'b1, cc_status(), CC_PAN_STEP, PAN_STEP_MID);
                else if (kind < 85)
                begin
                    len = $urandom_range(1, 30);
                    repeat (len)
                        send_tick(1'b0, STATUS_W'($urandom), DATA_W'($urandom),
                                  DATA_W'($urandom));
                end
                else
                begin
                    // Noise: note codes paired with controller numbers and the like.
                    len = $urandom_range(1, 10);
                    repeat (len)
                        send_tick(1'($urandom),
                                  ($urandom_range(0, 2) == 0) ? STATUS_NOTE_OFF :
                                  ($urandom_range(0, 1) == 0) ? STATUS_NOTE_ON :
                                                                STATUS_W'($urandom),
                                  ($urandom_range(0, 2) == 0) ? CC_PAN_STEP :
                                  ($urandom_range(0, 1) == 0) ? CC_PAN_CENTER :
                                                                DATA_W'($urandom),
                                  DATA_W'($urandom));
                end
            end
            phase_idx++;
        end

        drain();
        $display("Sent %0d ticks with %0d note-ons and %0d pan controllers over %0d settings.",
                 ticks_sent, notes_sent, pan_msgs_sent, settings_applied);
        $display("Compared %0d samples; output held off %0d times for %0d cycles each.",
                 samples_checked, holds_done, HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
